// ===== src/der_ticket_wrapper_skipper_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the DER ticket wrapper skipper
// Shared forms for concurrent checks, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef DER_TICKET_WRAPPER_SKIPPER_MACROS_SVH
`define DER_TICKET_WRAPPER_SKIPPER_MACROS_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define DTWS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent holds in the next cycle.
`define DTWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dtws_pkg.sv =====
// ---------------------------------------------------------------------------
// dtws_pkg
// Types and constants shared by the DER ticket wrapper skipper.
// ---------------------------------------------------------------------------
package dtws_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_TAG      = 2'd1;
    localparam logic [1:0] ST_LEN_FORM     = 2'd2;
    localparam logic [1:0] ST_LEN_MISMATCH = 2'd3;

    // DER tags expected in order.
    localparam logic [7:0] TAG_APP_TICKET = 8'h61;
    localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
    localparam logic [7:0] TAG_CTX0       = 8'hA0;
    localparam logic [7:0] TAG_CTX1       = 8'hA1;
    localparam logic [7:0] TAG_CTX2       = 8'hA2;
    localparam logic [7:0] TAG_CTX3       = 8'hA3;

    // Length byte: long-form flag and count mask.
    localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
    localparam logic [6:0] LEN_COUNT_MASK = 7'h7f;

    // Field indexes within the wrapper.
    localparam int unsigned FIELD_W = 3;
    localparam logic [FIELD_W-1:0] FLD_APP        = 3'd0;
    localparam logic [FIELD_W-1:0] FLD_SEQ        = 3'd1;
    localparam logic [FIELD_W-1:0] FLD_FIRST_SKIP = 3'd2;
    localparam logic [FIELD_W-1:0] FLD_CTX1       = 3'd3;
    localparam logic [FIELD_W-1:0] FLD_CTX2       = 3'd4;
    localparam logic [FIELD_W-1:0] FLD_ENC        = 3'd5;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] ticket_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data_offset;
        logic [15:0] data_length;
    } res_t;

    function automatic logic [7:0] expected_tag(input logic [FIELD_W-1:0] field);
        logic [7:0] tag;
        case (field)
            FLD_APP:        tag = TAG_APP_TICKET;
            FLD_SEQ:        tag = TAG_SEQUENCE;
            FLD_FIRST_SKIP: tag = TAG_CTX0;
            FLD_CTX1:       tag = TAG_CTX1;
            FLD_CTX2:       tag = TAG_CTX2;
            FLD_ENC:        tag = TAG_CTX3;
            default:        tag = TAG_CTX3;
        endcase
        return tag;
    endfunction

endpackage

// ===== src/dtws_in_if.sv =====
// ---------------------------------------------------------------------------
// dtws_in_if
// Byte channel into the ticket wrapper skipper: valid, ready and payload.
// ---------------------------------------------------------------------------
interface dtws_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] ticket_length;

    modport source (output valid, data_byte, first_byte, ticket_length, input ready);
    modport sink   (input valid, data_byte, first_byte, ticket_length, output ready);
endinterface

// ===== src/dtws_out_if.sv =====
// ---------------------------------------------------------------------------
// dtws_out_if
// Result channel out of the ticket wrapper skipper: valid, ready and payload.
// ---------------------------------------------------------------------------
interface dtws_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] data_offset;
    logic [15:0] data_length;

    modport source (output valid, status, data_offset, data_length, input ready);
    modport sink   (input valid, status, data_offset, data_length, output ready);
endinterface

// ===== src/der_ticket_wrapper_skipper.sv =====
// ---------------------------------------------------------------------------
// der_ticket_wrapper_skipper
// Walks the DER wrapper of a ticket and reports where its encrypted part lies.
// ---------------------------------------------------------------------------
//  Channel   Dir  Item                                      Accepted when
//  stream    in   data_byte, first_byte, ticket_length      valid & ready
//  result    out  status, data_offset, data_length          valid & ready
//
//  One byte is taken every cycle while the stream is not held off; it is stepped
//  from the input register, and its result, if any, waits in the result register.
//  The per-byte update of the parse state sits between these two registers.
//  Reset clears the parse state to idle and empties both registers.
//  While a result waits and is not taken, the parse step is held and the input register keeps
//  its byte; once that register is full the stream is held off.
module der_ticket_wrapper_skipper #(
    parameter int MAX_LENGTH_BYTES   = 4,
    parameter int TICKET_LENGTH_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    dtws_in_if.sink       stream,
    dtws_out_if.source    result
);
    import dtws_pkg::*;

    logic     in_vld_reg, in_vld_next;
    in_item_t in_item_reg;
    logic     res_vld_reg, res_vld_next;
    res_t     res_reg;

    logic     in_take;
    logic     step_en;
    logic     step_res_valid;
    res_t     step_res;

    assign step_en      = in_vld_reg & (~res_vld_reg | result.ready);
    assign stream.ready = ~in_vld_reg | step_en;
    assign in_take      = stream.valid & stream.ready;

    dtws_parser #(
        .MAX_LENGTH_BYTES   (MAX_LENGTH_BYTES),
        .TICKET_LENGTH_BITS (TICKET_LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .item      (in_item_reg),
        .res_valid (step_res_valid),
        .res       (step_res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (step_en)
        begin
            in_vld_next = 1'b0;
        end

        res_vld_next = res_vld_reg;
        if (step_res_valid)
        begin
            res_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.data_byte     <= stream.data_byte;
            in_item_reg.first_byte    <= stream.first_byte;
            in_item_reg.ticket_length <= stream.ticket_length;
        end
        if (step_res_valid)
        begin
            res_reg <= step_res;
        end
    end

    assign result.valid       = res_vld_reg;
    assign result.status      = res_reg.status;
    assign result.data_offset = res_reg.data_offset;
    assign result.data_length = res_reg.data_length;

endmodule

// ===== src/dtws_parser.sv =====
// ---------------------------------------------------------------------------
// dtws_parser
// Parse state and the per-byte update of the DER wrapper walk.
// ---------------------------------------------------------------------------
module dtws_parser #(
    parameter int MAX_LENGTH_BYTES   = 4,
    parameter int TICKET_LENGTH_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  dtws_pkg::in_item_t item,
    output logic              res_valid,
    output dtws_pkg::res_t    res
);
    import dtws_pkg::*;

    localparam int REM_W = (TICKET_LENGTH_BITS < 16) ? TICKET_LENGTH_BITS : 16;
    localparam int ACC_W = 8 * MAX_LENGTH_BYTES;
    localparam int LBL_W = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int CMP_W = (ACC_W > REM_W) ? ((ACC_W > 8) ? ACC_W : 8)
                                           : ((REM_W > 8) ? REM_W : 8);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG,
        PH_LENF,
        PH_LENM,
        PH_SKIP
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [FIELD_W-1:0]   field_reg, field_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [15:0]          off_reg, off_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [LBL_W-1:0]     lbl_reg, lbl_next;
    logic [REM_W-1:0]     skip_reg, skip_next;

    logic [REM_W-1:0]     rem_dec;
    logic [15:0]          off_inc;
    logic [6:0]           count;
    logic                 fin;
    logic [CMP_W-1:0]     rem_c;
    logic [CMP_W-1:0]     num_c;
    logic                 emit;
    res_t                 res_c;

    always_comb
    begin
        phase_next = phase_reg;
        field_next = field_reg;
        rem_next   = rem_reg;
        off_next   = off_reg;
        acc_next   = acc_reg;
        lbl_next   = lbl_reg;
        skip_next  = skip_reg;
        emit       = 1'b0;
        fin        = 1'b0;
        res_c      = '0;
        count      = item.data_byte[6:0] & LEN_COUNT_MASK;

        // A first byte restarts the walk from the outer tag.
        if (item.first_byte)
        begin
            phase_next = PH_TAG;
            field_next = FLD_APP;
            rem_next   = item.ticket_length[REM_W-1:0];
            off_next   = '0;
            acc_next   = '0;
            lbl_next   = '0;
            skip_next  = '0;
        end

        rem_dec = rem_next - 1'b1;
        off_inc = off_next + 16'd1;
        rem_c   = CMP_W'(rem_dec);
        num_c   = '0;

        if (phase_next == PH_IDLE)
        begin
            emit = 1'b0;
        end
        else if (rem_next == '0)
        begin
            emit         = 1'b1;
            res_c.status = ST_LEN_MISMATCH;
        end
        else
        begin
            rem_next = rem_dec;
            off_next = off_inc;
            case (phase_next)
                PH_TAG:
                begin
                    if (item.data_byte != expected_tag(field_next))
                    begin
                        emit         = 1'b1;
                        res_c.status = ST_BAD_TAG;
                    end
                    else if (rem_dec == '0)
                    begin
                        emit         = 1'b1;
                        res_c.status = ST_LEN_MISMATCH;
                    end
                    else
                    begin
                        phase_next = PH_LENF;
                    end
                end
                PH_LENF:
                begin
                    if ((item.data_byte & LEN_LONG_FLAG) != 8'd0)
                    begin
                        if (count > 7'(MAX_LENGTH_BYTES))
                        begin
                            emit         = 1'b1;
                            res_c.status = ST_LEN_FORM;
                        end
                        else
                        begin
                            acc_next = '0;
                            if (count == 7'd0)
                            begin
                                fin = 1'b1;
                            end
                            else if (rem_c < CMP_W'(count))
                            begin
                                emit         = 1'b1;
                                res_c.status = ST_LEN_MISMATCH;
                            end
                            else
                            begin
                                lbl_next   = LBL_W'(count);
                                phase_next = PH_LENM;
                            end
                        end
                    end
                    else
                    begin
                        acc_next = ACC_W'(item.data_byte);
                        fin      = 1'b1;
                    end
                end
                PH_LENM:
                begin
                    acc_next = ACC_W'({acc_next, item.data_byte});
                    if (lbl_next != '0)
                    begin
                        lbl_next = lbl_next - 1'b1;
                    end
                    fin = (lbl_next == '0);
                end
                PH_SKIP:
                begin
                    if (skip_next != '0)
                    begin
                        skip_next = skip_next - 1'b1;
                    end
                    if (skip_next == '0)
                    begin
                        phase_next = PH_TAG;
                        field_next = field_next + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // A complete length: check it against what is left of the ticket.
            if (fin)
            begin
                num_c = CMP_W'(acc_next);
                if (field_next < FLD_FIRST_SKIP)
                begin
                    if (rem_c != num_c || rem_dec == '0)
                    begin
                        emit         = 1'b1;
                        res_c.status = ST_LEN_MISMATCH;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                        field_next = field_next + 1'b1;
                    end
                end
                else if (field_next < FLD_ENC)
                begin
                    if (rem_c <= num_c)
                    begin
                        emit         = 1'b1;
                        res_c.status = ST_LEN_MISMATCH;
                    end
                    else if (num_c == '0)
                    begin
                        phase_next = PH_TAG;
                        field_next = field_next + 1'b1;
                    end
                    else
                    begin
                        // The skipped length is below the remaining count, so it fits.
                        skip_next  = num_c[REM_W-1:0];
                        phase_next = PH_SKIP;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    if (rem_c != num_c)
                    begin
                        res_c.status = ST_LEN_MISMATCH;
                    end
                    else
                    begin
                        res_c.status      = ST_OK;
                        res_c.data_offset = off_inc;
                        res_c.data_length = 16'(rem_dec);
                    end
                end
            end
        end

        if (emit)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            field_reg <= '0;
            rem_reg   <= '0;
            off_reg   <= '0;
            acc_reg   <= '0;
            lbl_reg   <= '0;
            skip_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            field_reg <= field_next;
            rem_reg   <= rem_next;
            off_reg   <= off_next;
            acc_reg   <= acc_next;
            lbl_reg   <= lbl_next;
            skip_reg  <= skip_next;
        end
    end

    assign res_valid = step_en & emit;
    assign res       = res_c;

endmodule

// ===== src/dtws_checker.sv =====
// ---------------------------------------------------------------------------
// dtws_checker
// Port-level checks on the ticket wrapper skipper, bound to the top level.
// ---------------------------------------------------------------------------
`include "der_ticket_wrapper_skipper_macros.svh"

module dtws_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] data_offset,
    input logic [15:0] data_length
);
    import dtws_pkg::*;

    // Six tags, each with at least one length byte, come before the encrypted part.
    localparam logic [15:0] MIN_ENC_OFFSET = 16'd12;

    // A fresh result comes from a taken byte, by way of the input register and the result register.
    `DTWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `DTWS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(status) && $stable(data_offset) && $stable(data_length), "result changed while stalled")
    `DTWS_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && status != ST_OK, data_offset == 16'd0 && data_length == 16'd0, "error result carries offset or length")
    `DTWS_ASSERT_IMPL(a_ok_offset, clk, rst_n, out_valid && status == ST_OK, data_offset >= MIN_ENC_OFFSET, "encrypted part starts inside the wrapper")
    `DTWS_ASSERT_IMPL(a_res_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a byte taken before it")

endmodule

bind der_ticket_wrapper_skipper dtws_checker u_dtws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (stream.valid),
    .in_ready    (stream.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .status      (result.status),
    .data_offset (result.data_offset),
    .data_length (result.data_length)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the DER ticket wrapper skipper
// Feeds ticket bytes over the stream channel and checks every result item
// against a byte-level model of the wrapper walk. A short table of directed
// bytes comes first, then generated tickets (well formed or damaged in about
// equal parts, some pure noise) under several idling and stalling patterns.
// ---------------------------------------------------------------------------
module tb_top;
    import dtws_pkg::*;

    localparam int unsigned MAX_LEN_OCTETS    = 4;
    localparam int          CYCLE_LIMIT       = 200000;
    localparam int          TAIL_CYCLES       = 8;
    localparam int          DRAIN_LIMIT       = 5000;
    localparam int          REPORT_LIMIT      = 10;
    localparam int          ITEMS_PER_PHASE   = 130;
    localparam int          TICKETS_PER_PHASE = 3;
    localparam int          HOLD_OFF_CYCLES   = 300;
    localparam int          DIR_ROWS          = 19;

    localparam logic [7:0] WRAPPER_TAG [6] = '{TAG_APP_TICKET, TAG_SEQUENCE, TAG_CTX0,
                                               TAG_CTX1, TAG_CTX2, TAG_CTX3};

    typedef enum logic [2:0] {
        WS_IDLE,
        WS_TAG,
        WS_LEN_FIRST,
        WS_LEN_MORE,
        WS_SKIP
    } walk_state_e;

    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_NONE,
        EXP_RESULT
    } exp_kind_e;

    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic [15:0] tlen;
        exp_kind_e   kind;
        logic [1:0]  st;
        logic [15:0] off;
        logic [15:0] len;
    } dir_row_t;

    logic clk;
    logic rst_n;

    dtws_in_if  in_ch ();
    dtws_out_if out_ch ();

    der_ticket_wrapper_skipper u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (in_ch),
        .result (out_ch)
    );

    // Directed bytes. Only results that are obvious are typed in; the rest
    // follow the model. The last ticket is a minimal well-formed wrapper.
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{8'h00, 1'b0, 16'h0000, EXP_NONE,    ST_OK,           16'd0,  16'd0},
        '{8'hFF, 1'b1, 16'h0000, EXP_RESULT,  ST_LEN_MISMATCH, 16'd0,  16'd0},
        '{8'h00, 1'b1, 16'hFFFF, EXP_RESULT,  ST_BAD_TAG,      16'd0,  16'd0},
        '{8'h61, 1'b1, 16'h0001, EXP_RESULT,  ST_LEN_MISMATCH, 16'd0,  16'd0},
        '{8'h61, 1'b1, 16'hFFFF, EXP_NONE,    ST_OK,           16'd0,  16'd0},
        '{8'hFF, 1'b0, 16'hFFFF, EXP_RESULT,  ST_LEN_FORM,     16'd0,  16'd0},
        '{8'h61, 1'b1, 16'd13,   EXP_NONE,    ST_OK,           16'd0,  16'd0},
        '{8'h0B, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'h30, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'h09, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'hA0, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'h00, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'hA1, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'h80, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'hA2, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'h00, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'hA3, 1'b0, 16'h0000, EXP_PREDICT, ST_OK,           16'd0,  16'd0},
        '{8'h01, 1'b0, 16'h0000, EXP_RESULT,  ST_OK,           16'd12, 16'd1},
        '{8'h5A, 1'b0, 16'hA5C3, EXP_NONE,    ST_OK,           16'd0,  16'd0}
    };

    // Model state of the wrapper walk.
    walk_state_e ws_state    = WS_IDLE;
    logic [16:0] ws_rem      = '0;
    logic [15:0] ws_off      = '0;
    logic [31:0] ws_acc      = '0;
    logic [2:0]  ws_len_left = '0;
    logic [31:0] ws_skip     = '0;
    logic [2:0]  ws_field    = '0;

    res_t        due_results [$];
    logic [7:0]  tkt [$];
    in_item_t    gen_q [$];

    exp_kind_e   cur_kind = EXP_PREDICT;
    res_t        cur_exp  = '0;

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_req        = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int n_fail          = 0;
    int n_bytes         = 0;
    int n_starts        = 0;
    int n_results       = 0;
    int n_hold_cycles   = 0;
    int n_stream_stalls = 0;
    int status_count [4] = '{0, 0, 0, 0};

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit finish_ticket(output res_t r, input logic [1:0] st,
                                         input logic [15:0] o, input logic [15:0] l);
        r.status      = st;
        r.data_offset = o;
        r.data_length = l;
        ws_state      = WS_IDLE;
        return 1'b1;
    endfunction

    // A complete length has been read for the current field.
    function automatic bit close_length(output res_t r);
        r = '0;
        if (ws_field < FLD_FIRST_SKIP) begin
            if (ws_rem != ws_acc || ws_rem == 17'd0)
                return finish_ticket(r, ST_LEN_MISMATCH, 16'd0, 16'd0);
            ws_field = ws_field + 3'd1;
            ws_state = WS_TAG;
            return 1'b0;
        end
        if (ws_field < FLD_ENC) begin
            // A skipped field must leave room for at least the next tag.
            if (ws_rem <= ws_acc)
                return finish_ticket(r, ST_LEN_MISMATCH, 16'd0, 16'd0);
            ws_skip = ws_acc;
            if (ws_acc != 32'd0) begin
                ws_state = WS_SKIP;
            end
            else begin
                ws_field = ws_field + 3'd1;
                ws_state = WS_TAG;
            end
            return 1'b0;
        end
        if (ws_rem != ws_acc)
            return finish_ticket(r, ST_LEN_MISMATCH, 16'd0, 16'd0);
        return finish_ticket(r, ST_OK, ws_off, ws_rem[15:0]);
    endfunction

    // Advances the wrapper walk by one byte; returns 1 when a result is due.
    function automatic bit parse_ticket_byte(input in_item_t it, output res_t r);
        logic [6:0] cnt;
        r = '0;
        if (it.first_byte) begin
            ws_rem      = {1'b0, it.ticket_length};
            ws_off      = '0;
            ws_acc      = '0;
            ws_len_left = '0;
            ws_skip     = '0;
            ws_field    = FLD_APP;
            ws_state    = WS_TAG;
            if (ws_rem == 17'd0)
                return finish_ticket(r, ST_LEN_MISMATCH, 16'd0, 16'd0);
        end
        if (ws_state == WS_IDLE)
            return 1'b0;
        if (ws_rem == 17'd0)
            return finish_ticket(r, ST_LEN_MISMATCH, 16'd0, 16'd0);
        ws_rem = ws_rem - 17'd1;
        ws_off = ws_off + 16'd1;
        case (ws_state)
            WS_TAG: begin
                if (it.data_byte != WRAPPER_TAG[ws_field])
                    return finish_ticket(r, ST_BAD_TAG, 16'd0, 16'd0);
                if (ws_rem == 17'd0)
                    return finish_ticket(r, ST_LEN_MISMATCH, 16'd0, 16'd0);
                ws_state = WS_LEN_FIRST;
            end
            WS_LEN_FIRST: begin
                if ((it.data_byte & LEN_LONG_FLAG) != 8'd0) begin
                    cnt = it.data_byte[6:0] & LEN_COUNT_MASK;
                    // An oversized count is reported ahead of any truncation.
                    if (cnt > MAX_LEN_OCTETS)
                        return finish_ticket(r, ST_LEN_FORM, 16'd0, 16'd0);
                    ws_acc = '0;
                    if (cnt == 7'd0)
                        return close_length(r);
                    if (ws_rem < cnt)
                        return finish_ticket(r, ST_LEN_MISMATCH, 16'd0, 16'd0);
                    ws_len_left = cnt[2:0];
                    ws_state    = WS_LEN_MORE;
                end
                else begin
                    ws_acc = {24'd0, it.data_byte};
                    return close_length(r);
                end
            end
            WS_LEN_MORE: begin
                ws_acc = {ws_acc[23:0], it.data_byte};
                if (ws_len_left != 3'd0)
                    ws_len_left = ws_len_left - 3'd1;
                if (ws_len_left == 3'd0)
                    return close_length(r);
            end
            default: begin
                if (ws_skip != 32'd0)
                    ws_skip = ws_skip - 32'd1;
                if (ws_skip == 32'd0) begin
                    ws_field = ws_field + 3'd1;
                    ws_state = WS_TAG;
                end
            end
        endcase
        return 1'b0;
    endfunction

    task automatic report_failure(input string what, input res_t want, input res_t got);
        n_fail++;
        if (n_fail <= REPORT_LIMIT)
            $display("%s: expected status %0d offset %0d length %0d, got status %0d offset %0d length %0d",
                     what, want.status, want.data_offset, want.data_length,
                     got.status, got.data_offset, got.data_length);
    endtask

    // Both channels are sampled at the rising edge.
    always @(posedge clk) begin : monitor
        in_item_t it;
        res_t     r;
        res_t     got;
        res_t     want;
        bit       made;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                it.data_byte     = in_ch.data_byte;
                it.first_byte    = in_ch.first_byte;
                it.ticket_length = in_ch.ticket_length;
                n_bytes++;
                if (it.first_byte)
                    n_starts++;
                made = parse_ticket_byte(it, r);
                case (cur_kind)
                    EXP_RESULT:  due_results.push_back(cur_exp);
                    EXP_PREDICT: if (made) due_results.push_back(r);
                    default:     ;
                endcase
            end
            if (in_ch.valid && !in_ch.ready)
                n_stream_stalls++;
            if (out_ch.valid && out_ch.ready) begin
                got.status      = out_ch.status;
                got.data_offset = out_ch.data_offset;
                got.data_length = out_ch.data_length;
                n_results++;
                status_count[got.status]++;
                if (due_results.size() == 0) begin
                    report_failure("result with none due", '0, got);
                end
                else begin
                    want = due_results.pop_front();
                    if (want.status != got.status || want.data_offset != got.data_offset
                        || want.data_length != got.data_length)
                        report_failure("result mismatch", want, got);
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            n_hold_cycles++;
            out_ch.ready <= 1'b0;
        end
        else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high.
    task automatic offer(input in_item_t it, input exp_kind_e kind, input res_t exp_res);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cur_kind = kind;
        cur_exp  = exp_res;
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= it.data_byte;
        in_ch.first_byte    <= it.first_byte;
        in_ch.ticket_length <= it.ticket_length;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int long_octets(input int unsigned v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 8;
        end
        return n;
    endfunction

    // -1 selects the short form, otherwise the number of long-form octets.
    function automatic int pick_form(input int unsigned v);
        if (v < 128 && $urandom_range(1) == 0)
            return -1;
        return $urandom_range(MAX_LEN_OCTETS, long_octets(v));
    endfunction

    function automatic int form_size(input int f);
        return (f < 0) ? 1 : 1 + f;
    endfunction

    function automatic void push_len(input int unsigned v, input int f);
        if (f < 0) begin
            tkt.push_back(8'(v));
        end
        else begin
            tkt.push_back(LEN_LONG_FLAG | 8'(f));
            for (int i = f - 1; i >= 0; i--)
                tkt.push_back(8'(v >> (8 * i)));
        end
    endfunction

    // Fills gen_q with one ticket, well formed or damaged in about equal parts,
    // or with a burst of noise.
    task automatic build_stream();
        int unsigned clen [4];
        int          form [4];
        int unsigned seq_len;
        int unsigned app_len;
        int unsigned total;
        int          seq_f;
        int          app_f;
        int          restart_at;
        int          cut;
        int          n;
        logic [15:0] tl;
        in_item_t    x;
        gen_q.delete();
        if ($urandom_range(7) == 0) begin
            n = $urandom_range(16, 1);
            for (int i = 0; i < n; i++) begin
                x.data_byte     = 8'($urandom);
                x.first_byte    = (i == 0) || ($urandom_range(7) == 0);
                x.ticket_length = ($urandom_range(1) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(20));
                gen_q.push_back(x);
            end
            return;
        end
        seq_len = 0;
        for (int i = 0; i < 4; i++) begin
            clen[i] = ($urandom_range(39) == 0) ? $urandom_range(300, 128)
                                                : $urandom_range(i == 3 ? 8 : 4);
            form[i] = pick_form(clen[i]);
            seq_len += 1 + form_size(form[i]) + clen[i];
        end
        seq_f   = pick_form(seq_len);
        app_len = 1 + form_size(seq_f) + seq_len;
        app_f   = pick_form(app_len);
        total   = 1 + form_size(app_f) + app_len;
        tkt.delete();
        tkt.push_back(TAG_APP_TICKET);
        push_len(app_len, app_f);
        tkt.push_back(TAG_SEQUENCE);
        push_len(seq_len, seq_f);
        for (int i = 0; i < 4; i++) begin
            tkt.push_back(WRAPPER_TAG[FLD_FIRST_SKIP + i]);
            push_len(clen[i], form[i]);
            repeat (clen[i]) tkt.push_back(8'($urandom));
        end
        tl = 16'(total);
        restart_at = -1;
        case ($urandom_range(11))
            0: tkt[$urandom_range(tkt.size() - 1)] = 8'($urandom);
            1: tl = 16'(total + $urandom_range(4) - 2);
            2: begin
                cut = $urandom_range(tkt.size() - 1, 1);
                while (tkt.size() > cut)
                    void'(tkt.pop_back());
            end
            3: tkt[$urandom_range(3)] = 8'($urandom_range(255, 133));
            4: restart_at = $urandom_range(tkt.size() - 1, 1);
            5: tl = 16'($urandom);
            default: ;
        endcase
        foreach (tkt[i]) begin
            x.data_byte  = tkt[i];
            x.first_byte = (i == 0) || (i == restart_at);
            if (i == 0)
                x.ticket_length = tl;
            else if (i == restart_at)
                x.ticket_length = 16'($urandom_range(40));
            else
                x.ticket_length = 16'($urandom);
            gen_q.push_back(x);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int hold);
        int items;
        int tickets;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        send_idle_pct = idle;
        stall_pct     = stall;
        hold_req      = hold;
        @(negedge clk);
        items   = 0;
        tickets = 0;
        while (tickets < TICKETS_PER_PHASE || items < ITEMS_PER_PHASE) begin
            build_stream();
            tickets++;
            foreach (gen_q[i])
                offer(gen_q[i], EXP_PREDICT, '0);
            items += gen_q.size();
        end
    endtask

    initial begin : stimulus
        dir_row_t row;
        in_item_t it;
        res_t     r;
        int       drain;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = '0;
        in_ch.first_byte    = 1'b0;
        in_ch.ticket_length = '0;
        out_ch.ready        = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row              = dir_tab[i];
            it.data_byte     = row.data;
            it.first_byte    = row.first;
            it.ticket_length = row.tlen;
            r.status         = row.st;
            r.data_offset    = row.off;
            r.data_length    = row.len;
            offer(it, row.kind, r);
        end

        // Full rate with a long result hold-off first, so the block backs up.
        run_phase(0, 0, HOLD_OFF_CYCLES);
        run_phase(64, 0, 0);
        run_phase(0, 64, 0);
        run_phase(20, 20, 0);
        in_ch.valid <= 1'b0;

        drain = 0;
        while (due_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_results.size() != 0) begin
            $display("%0d expected results never arrived", due_results.size());
            n_fail += due_results.size();
        end

        $display("Walked %0d bytes with %0d ticket starts; %0d results: ok %0d, bad tag %0d, long length form %0d, length mismatch %0d.",
                 n_bytes, n_starts, n_results, status_count[ST_OK], status_count[ST_BAD_TAG],
                 status_count[ST_LEN_FORM], status_count[ST_LEN_MISMATCH]);
        $display("Result side held off for %0d cycles; byte stream back-pressured for %0d cycles.",
                 n_hold_cycles, n_stream_stalls);
        if (n_fail == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
